@@ hdl/rcs_pkg.sv @@
// package: sequencer step codes, control word layout and microcode rom
package rcs_pkg;

    typedef enum logic [2:0]
    {
        ST_LOAD   = 3'd0,
        ST_CHECK  = 3'd1,
        ST_RD_LO  = 3'd2,
        ST_RD_HI  = 3'd3,
        ST_RD_MID = 3'd4,
        ST_DECIDE = 3'd5,
        ST_DONE   = 3'd6
    } step_t;

    typedef enum logic [1:0]
    {
        RD_LOW  = 2'd0,
        RD_HIGH = 2'd1,
        RD_MID  = 2'd2
    } rd_sel_t;

    typedef enum logic [2:0]
    {
        JC_NEVER    = 3'd0,
        JC_ALWAYS   = 3'd1,
        JC_LAST     = 3'd2,
        JC_LO_GE_HI = 3'd3,
        JC_OUT_FREE = 3'd4
    } jump_cond_t;

    typedef struct packed
    {
        logic       accept;
        rd_sel_t    rd_sel;
        logic       calc_mid;
        logic       cap_kl;
        logic       cap_kh;
        logic       decide;
        logic       finish;
        jump_cond_t cond;
        step_t      target;
        logic       hold;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode_rom(input step_t pc);
        ctrl_word_t w;
        w = '{accept: 1'b0, rd_sel: RD_LOW, calc_mid: 1'b0, cap_kl: 1'b0, cap_kh: 1'b0,
              decide: 1'b0, finish: 1'b0, cond: JC_NEVER, target: ST_LOAD, hold: 1'b0};
        unique case (pc)
            ST_LOAD:
            begin
                w.accept = 1'b1;
                w.cond   = JC_LAST;
                w.target = ST_CHECK;
                w.hold   = 1'b1;
            end
            ST_CHECK:
            begin
                w.cond   = JC_LO_GE_HI;
                w.target = ST_DONE;
            end
            ST_RD_LO:
            begin
                w.rd_sel   = RD_LOW;
                w.calc_mid = 1'b1;
            end
            ST_RD_HI:
            begin
                w.rd_sel = RD_HIGH;
                w.cap_kl = 1'b1;
            end
            ST_RD_MID:
            begin
                w.rd_sel = RD_MID;
                w.cap_kh = 1'b1;
            end
            ST_DECIDE:
            begin
                w.decide = 1'b1;
                w.cond   = JC_ALWAYS;
                w.target = ST_CHECK;
            end
            ST_DONE:
            begin
                w.finish = 1'b1;
                w.cond   = JC_OUT_FREE;
                w.target = ST_LOAD;
                w.hold   = 1'b1;
            end
            default:
            begin
                w.cond   = JC_ALWAYS;
                w.target = ST_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/rcs_store.sv @@
// element store: one write port, one read port with registered read data
module rcs_store
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 10
)
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [IDX_W-1:0]      waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic [IDX_W-1:0]      raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/rotation_count_search_unit.sv @@
// top level: element loading and microcoded binary search for the rotation count
//
//  channel  | dir | payload                                         | transaction
//  s_axis   | in  | tdata[31:0] element_value, tlast is_last        | tvalid & tready
//  m_axis   | out | tdata[9:0] rotation_count, tdata[10] overflow   | tvalid & tready
//
// loading takes one element per cycle; s_axis_tready is high only in the load step
// the search then runs a seven-step microprogram: each halving is a range check,
// three reads through the single read port of the store and one decision; the
// result follows once the range check finds low no longer below high
// reset clears the sequencer, element count, overflow flag and output valid; the store is not cleared
// a stalled result waits in the output register; the sequencer holds in its last step
// until the register is free, then returns to loading
module rotation_count_search_unit
    import rcs_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] element_value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [9:0] rotation_count, [10] overflow, rest zero
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    step_t      pc_reg, pc_next;
    ctrl_word_t cw;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] low_reg, low_next;
    logic [IDX_W-1:0] high_reg, high_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [DATA_WIDTH-1:0] kl_reg, kh_reg;

    logic        out_valid_reg, out_valid_next;
    logic [9:0]  out_count_reg;
    logic        out_ovf_reg;

    logic                  full;
    logic                  in_xfer;
    logic                  out_free;
    logic                  cond_true;
    logic [IDX_W-1:0]      raddr;
    logic [DATA_WIDTH-1:0] rdata;
    logic [63:0]           elem_ext;
    logic [DATA_WIDTH-1:0] wdata;

    assign cw       = ucode_rom(pc_reg);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign in_xfer  = s_axis_tvalid && cw.accept;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign elem_ext = 64'(signed'(s_axis_tdata));
    assign wdata    = elem_ext[DATA_WIDTH-1:0];

    always_comb
    begin
        unique case (cw.rd_sel)
            RD_LOW:  raddr = low_reg;
            RD_HIGH: raddr = high_reg;
            RD_MID:  raddr = mid_reg;
            default: raddr = low_reg;
        endcase
    end

    rcs_store
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    )
    u_store
    (
        .clk   (clk),
        .we    (in_xfer && !full),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // jump condition and step counter
    always_comb
    begin
        unique case (cw.cond)
            JC_NEVER:    cond_true = 1'b0;
            JC_ALWAYS:   cond_true = 1'b1;
            JC_LAST:     cond_true = in_xfer && s_axis_tlast;
            JC_LO_GE_HI: cond_true = (low_reg >= high_reg);
            JC_OUT_FREE: cond_true = out_free;
            default:     cond_true = 1'b1;
        endcase

        priority if (cond_true)
        begin
            pc_next = cw.target;
        end
        else if (cw.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = step_t'(3'(pc_reg) + 3'd1);
        end
    end

    // datapath
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (in_xfer)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (s_axis_tlast)
            begin
                low_next  = '0;
                high_next = full ? IDX_W'(DEPTH - 1) : count_reg[IDX_W-1:0];
            end
        end

        if (cw.calc_mid)
        begin
            mid_next = low_reg + ((high_reg - low_reg) >> 1);
        end

        if (cw.decide)
        begin
            // an already sorted range collapses onto low
            priority if ($signed(kl_reg) < $signed(kh_reg))
            begin
                high_next = low_reg;
            end
            else if ($signed(rdata) < $signed(kl_reg))
            begin
                high_next = mid_reg;
            end
            else
            begin
                low_next = mid_reg + IDX_W'(1);
            end
        end

        if (cw.finish && out_free)
        begin
            out_valid_next = 1'b1;
            count_next     = '0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        if (cw.cap_kl)
        begin
            kl_reg <= rdata;
        end
        if (cw.cap_kh)
        begin
            kh_reg <= rdata;
        end
        if (cw.finish && out_free)
        begin
            out_count_reg <= 10'(low_reg);
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign s_axis_tready = cw.accept;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_ovf_reg, out_count_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond store depth");

    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != ST_LOAD) |-> (low_reg <= high_reg))
        else $error("search range inverted");

    a_set_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.finish && out_free) |=> (count_reg == '0) && !ovf_reg && m_axis_tvalid
                                    && (pc_reg == ST_LOAD))
        else $error("set not closed after result");

endmodule
